@@ rtl/core/peer_presence_table_aging_unit_assert.svh @@
// ----------------------------------------------------------------------------
// peer presence table aging unit - assertion macros
// concurrent assertion helpers, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef PEER_PRESENCE_TABLE_AGING_UNIT_ASSERT_SVH
`define PEER_PRESENCE_TABLE_AGING_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PPTA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PPTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PPTA_ASSERT_SAME(lbl, ante, cons, msg)
`define PPTA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/ppta_pkg.sv @@
// ----------------------------------------------------------------------------
// ppta_pkg
// shared types and constants of the peer presence table aging unit
// ----------------------------------------------------------------------------
package ppta_pkg;

  localparam int ID_W      = 64;
  localparam int SEQ_W     = 32;
  localparam int NOW_W     = 32;
  localparam int LEN_W     = 16;
  localparam int KIND_W    = 8;
  localparam int TTL_W     = 20;
  localparam int SLOT_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam logic [KIND_W-1:0] KIND_AUDIO = 8'h41;
  localparam logic [KIND_W-1:0] KIND_HELLO = 8'h48;
  localparam logic [KIND_W-1:0] KIND_BYE   = 8'h42;

  localparam logic [LEN_W-1:0] HEADER_BYTES       = 16'd17;
  localparam logic [LEN_W-1:0] AUDIO_HEADER_BYTES = 16'd21;
  localparam logic [TTL_W-1:0] TTL_RESET          = 20'd6000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ID_HIGH = 2'd0,
    REG_OWN_ID_LOW  = 2'd1,
    REG_TTL_MS      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_IGNORED    = 3'd0,
    EV_JOINED     = 3'd1,
    EV_REFRESHED  = 3'd2,
    EV_LEFT       = 3'd3,
    EV_EXPIRED    = 3'd4,
    EV_TABLE_FULL = 3'd5,
    EV_SWEEP_DONE = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    CMD_IGNORE = 2'd0,
    CMD_BYE    = 2'd1,
    CMD_TOUCH  = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ID_W-1:0]    id_high;
    logic [ID_W-1:0]    id_low;
    logic               name;
    logic               av;
    logic [SEQ_W-1:0]   seq;
    logic [NOW_W-1:0]   now;
  } cmd_t;

  typedef struct packed {
    event_t             ev;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id_high;
    logic [ID_W-1:0]    id_low;
    logic               name;
    logic               av;
    logic [SEQ_W-1:0]   seq;
    logic               last;
  } res_t;

endpackage

@@ rtl/core/peer_presence_table_aging_unit.sv @@
// ----------------------------------------------------------------------------
// peer_presence_table_aging_unit
// presence table of remote senders with last-seen times and ttl aging
// ----------------------------------------------------------------------------
// items enter through push/full and leave through empty/pop; both sides are
// queues. registers are written on the cfg channel (cfg_ready is always high);
// the user must write them only while the block is idle, which the block
// does not enforce. an accepted item is classified in the same cycle and
// queued as a command. the engine then scans every table slot through the
// slot store read port, one slot a cycle while the result queue has room,
// and acts on the result: a packet item gives its single result after the
// scan, a sweep streams one result per expired slot as the scan reaches it
// and the done result at the end. a packet dropped on length, topic or own
// id skips the scan. the engine takes a new item only once it is through
// with the last, as the slot store has a single read port.
// reset empties both queues, invalidates all slots, clears the own id and
// sets ttl_ms to 6000. while pop is held low the result queue fills and the
// scan pauses; the command queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
`include "peer_presence_table_aging_unit_assert.svh"

module peer_presence_table_aging_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppta_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic                                op,
  input  logic                                topic_match,
  input  logic [ppta_pkg::LEN_W-1:0]          packet_length,
  input  logic [ppta_pkg::KIND_W-1:0]         kind,
  input  logic [ppta_pkg::ID_W-1:0]           sender_id_high,
  input  logic [ppta_pkg::ID_W-1:0]           sender_id_low,
  input  logic [ppta_pkg::SEQ_W-1:0]          audio_seq_in,
  input  logic [ppta_pkg::NOW_W-1:0]          now_ms,
  output logic                                empty,
  input  logic                                pop,
  output logic [2:0]                          event_res,
  output logic [ppta_pkg::SLOT_W-1:0]         slot,
  output logic [ppta_pkg::ID_W-1:0]           peer_id_high,
  output logic [ppta_pkg::ID_W-1:0]           peer_id_low,
  output logic                                name_carried,
  output logic                                audio_valid,
  output logic [ppta_pkg::SEQ_W-1:0]          audio_seq,
  output logic                                last
);

  import ppta_pkg::*;

  cmd_t              cmd_w;
  cmd_t              cmd_q;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [TTL_W-1:0]  ttl_ms;
  logic              res_full;
  logic              res_push;
  res_t              res_d;
  res_t              res_q;
  logic              res_mid;
  logic              res_done;
  logic              done_clean;

  assign cfg_ready = 1'b1;

  ppta_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .topic_match    (topic_match),
    .packet_length  (packet_length),
    .kind           (kind),
    .sender_id_high (sender_id_high),
    .sender_id_low  (sender_id_low),
    .audio_seq_in   (audio_seq_in),
    .now_ms         (now_ms),
    .cmd            (cmd_w),
    .ttl_ms         (ttl_ms)
  );

  ppta_fifo #(
    .T     (cmd_t),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_w),
    .rd_en   (cmd_pop),
    .rd_data (cmd_q),
    .full    (full),
    .empty   (cmd_empty)
  );

  ppta_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_in    (cmd_q),
    .cmd_pop   (cmd_pop),
    .ttl_ms    (ttl_ms),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_d     (res_d)
  );

  ppta_fifo #(
    .T     (res_t),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_d),
    .rd_en   (pop),
    .rd_data (res_q),
    .full    (res_full),
    .empty   (empty)
  );

  assign event_res    = res_q.ev;
  assign slot         = res_q.slot;
  assign peer_id_high = res_q.id_high;
  assign peer_id_low  = res_q.id_low;
  assign name_carried = res_q.name;
  assign audio_valid  = res_q.av;
  assign audio_seq    = res_q.seq;
  assign last         = res_q.last;

  assign res_mid    = !empty && !last;
  assign res_done   = !empty && (event_res == EV_SWEEP_DONE);
  assign done_clean = last && (slot == '0) && (peer_id_high == '0) && (peer_id_low == '0);

  `PPTA_ASSERT_SAME(a_res_no_overflow, res_push, !res_full, "result pushed into a full queue")
  `PPTA_ASSERT_SAME(a_mid_is_expiry, res_mid, event_res == EV_EXPIRED, "mid result not expiry")
  `PPTA_ASSERT_SAME(a_done_is_clean, res_done, done_clean, "sweep done carries slot or id")
  `PPTA_ASSERT_NEXT(a_one_cmd_at_a_time, cmd_pop, !cmd_pop, "commands taken back to back")

endmodule

@@ rtl/core/ppta_fifo.sv @@
// ----------------------------------------------------------------------------
// ppta_fifo
// small first-in first-out queue of a generic item type
// ----------------------------------------------------------------------------
module ppta_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  T     wr_data,
  input  logic rd_en,
  output T     rd_data,
  output logic full,
  output logic empty
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);

  T                  mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/ppta_front.sv @@
// ----------------------------------------------------------------------------
// ppta_front
// configuration registers and classification of incoming items into commands
// ----------------------------------------------------------------------------
module ppta_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ppta_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppta_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 op,
  input  logic                                 topic_match,
  input  logic [ppta_pkg::LEN_W-1:0]           packet_length,
  input  logic [ppta_pkg::KIND_W-1:0]          kind,
  input  logic [ppta_pkg::ID_W-1:0]            sender_id_high,
  input  logic [ppta_pkg::ID_W-1:0]            sender_id_low,
  input  logic [ppta_pkg::SEQ_W-1:0]           audio_seq_in,
  input  logic [ppta_pkg::NOW_W-1:0]           now_ms,
  output ppta_pkg::cmd_t                       cmd,
  output logic [ppta_pkg::TTL_W-1:0]           ttl_ms
);

  import ppta_pkg::*;

  logic [ID_W-1:0] own_id_high;
  logic [ID_W-1:0] own_id_low;
  logic            drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id_high <= '0;
      own_id_low  <= '0;
      ttl_ms      <= TTL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_ID_HIGH: own_id_high <= cfg_data;
        REG_OWN_ID_LOW:  own_id_low  <= cfg_data;
        REG_TTL_MS:      ttl_ms      <= cfg_data[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  assign drop = (packet_length < HEADER_BYTES) || !topic_match ||
                ((sender_id_high == own_id_high) && (sender_id_low == own_id_low));

  always_comb begin
    cmd      = '0;
    cmd.now  = now_ms;
    if (op) begin
      cmd.kind = CMD_SWEEP;
    end else if (drop) begin
      cmd.kind = CMD_IGNORE;
    end else begin
      cmd.id_high = sender_id_high;
      cmd.id_low  = sender_id_low;
      if (kind == KIND_BYE) begin
        cmd.kind = CMD_BYE;
      end else begin
        cmd.kind = CMD_TOUCH;
        cmd.name = (kind == KIND_HELLO) && (packet_length > HEADER_BYTES);
        cmd.av   = (kind == KIND_AUDIO) && (packet_length > AUDIO_HEADER_BYTES);
        cmd.seq  = cmd.av ? audio_seq_in : '0;
      end
    end
  end

endmodule

@@ rtl/core/ppta_engine.sv @@
// ----------------------------------------------------------------------------
// ppta_engine
// table store and slot scan that carries out lookups, updates and sweeps
// ----------------------------------------------------------------------------
module ppta_engine #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  input  ppta_pkg::cmd_t              cmd_in,
  output logic                        cmd_pop,
  input  logic [ppta_pkg::TTL_W-1:0]  ttl_ms,
  input  logic                        res_full,
  output logic                        res_push,
  output ppta_pkg::res_t              res_d
);

  import ppta_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (TIME_BITS > TTL_W) ? TIME_BITS : TTL_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT
  } state_t;

  state_t               state;
  cmd_t                 cmd;
  logic [TABLE_DEPTH-1:0] valid;
  logic                 iss_on;
  logic [IDX_W-1:0]     iss_idx;
  logic                 ev_vld;
  logic [IDX_W-1:0]     ev_idx;
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;

  logic [ID_W-1:0]      mem_hi   [TABLE_DEPTH];
  logic [ID_W-1:0]      mem_lo   [TABLE_DEPTH];
  logic [TIME_BITS-1:0] mem_time [TABLE_DEPTH];
  logic [ID_W-1:0]      rd_hi;
  logic [ID_W-1:0]      rd_lo;
  logic [TIME_BITS-1:0] rd_time;

  logic                 adv;
  logic                 rd_en;
  logic                 we;
  logic [IDX_W-1:0]     wr_idx;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] age;
  logic                 expired;
  logic                 id_hit;
  logic                 sweep_hit;

  assign adv       = !res_full;
  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;
  assign rd_en     = (state == S_SCAN) && adv && iss_on;
  assign now_t     = TIME_BITS'(cmd.now);
  assign age       = now_t - rd_time;
  assign expired   = CMP_W'(age) > CMP_W'(ttl_ms);
  assign id_hit    = valid[ev_idx] && (rd_hi == cmd.id_high) && (rd_lo == cmd.id_low);
  assign sweep_hit = (state == S_SCAN) && ev_vld && (cmd.kind == CMD_SWEEP) &&
                     valid[ev_idx] && expired;
  assign wr_idx    = found ? found_idx : free_idx;
  assign we        = (state == S_ACT) && adv && (cmd.kind == CMD_TOUCH) &&
                     (found || free_found);

  always_ff @(posedge clk) begin
    if (we) begin
      mem_hi[wr_idx]   <= cmd.id_high;
      mem_lo[wr_idx]   <= cmd.id_low;
      mem_time[wr_idx] <= now_t;
    end
    if (rd_en) begin
      rd_hi   <= mem_hi[iss_idx];
      rd_lo   <= mem_lo[iss_idx];
      rd_time <= mem_time[iss_idx];
    end
  end

  always_comb begin
    res_push = 1'b0;
    res_d    = '0;
    if (sweep_hit && adv) begin
      res_push     = 1'b1;
      res_d.ev     = EV_EXPIRED;
      res_d.slot   = SLOT_W'(ev_idx);
      res_d.id_high = rd_hi;
      res_d.id_low  = rd_lo;
    end else if ((state == S_ACT) && adv) begin
      res_push = 1'b1;
      res_d.last = 1'b1;
      case (cmd.kind)
        CMD_SWEEP: begin
          res_d.ev = EV_SWEEP_DONE;
        end
        CMD_BYE: begin
          res_d.id_high = cmd.id_high;
          res_d.id_low  = cmd.id_low;
          res_d.ev      = found ? EV_LEFT : EV_IGNORED;
          res_d.slot    = found ? SLOT_W'(found_idx) : '0;
        end
        CMD_TOUCH: begin
          res_d.id_high = cmd.id_high;
          res_d.id_low  = cmd.id_low;
          res_d.name    = cmd.name;
          res_d.av      = cmd.av;
          res_d.seq     = cmd.seq;
          if (found) begin
            res_d.ev   = EV_REFRESHED;
            res_d.slot = SLOT_W'(found_idx);
          end else if (free_found) begin
            res_d.ev   = EV_JOINED;
            res_d.slot = SLOT_W'(free_idx);
          end else begin
            res_d.ev   = EV_TABLE_FULL;
          end
        end
        default: begin
          res_d.ev = EV_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      iss_on     <= 1'b0;
      iss_idx    <= '0;
      ev_vld     <= 1'b0;
      ev_idx     <= '0;
      found      <= 1'b0;
      found_idx  <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd        <= cmd_in;
            found      <= 1'b0;
            free_found <= 1'b0;
            iss_idx    <= '0;
            ev_vld     <= 1'b0;
            iss_on     <= (cmd_in.kind != CMD_IGNORE);
            state      <= (cmd_in.kind == CMD_IGNORE) ? S_ACT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (adv) begin
            if (iss_on) begin
              ev_vld <= 1'b1;
              ev_idx <= iss_idx;
              if (iss_idx == IDX_LAST) begin
                iss_on <= 1'b0;
              end else begin
                iss_idx <= iss_idx + 1'b1;
              end
            end else begin
              ev_vld <= 1'b0;
            end
            if (ev_vld) begin
              if (cmd.kind == CMD_SWEEP) begin
                if (sweep_hit) begin
                  valid[ev_idx] <= 1'b0;
                end
              end else begin
                if (id_hit && !found) begin
                  found     <= 1'b1;
                  found_idx <= ev_idx;
                end
                if (!valid[ev_idx] && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= ev_idx;
                end
              end
              if (ev_idx == IDX_LAST) begin
                state <= S_ACT;
              end
            end
          end
        end
        S_ACT: begin
          if (adv) begin
            if ((cmd.kind == CMD_BYE) && found) begin
              valid[found_idx] <= 1'b0;
            end
            if ((cmd.kind == CMD_TOUCH) && !found && free_found) begin
              valid[free_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
